>>> sv/bdic_pkg.sv
`timescale 1ns / 1ps
package bdic_pkg;
	localparam int WordW = 64;
	localparam int CodeW = 3;
	localparam int ValW = 33;
	localparam int InDataW = 72;
	localparam int OutDataW = 40;

	typedef enum logic [CodeW-1:0] {
		CODE_I8  = 3'd0,
		CODE_U8  = 3'd1,
		CODE_I16 = 3'd2,
		CODE_U16 = 3'd3,
		CODE_I32 = 3'd4,
		CODE_U32 = 3'd5
	} code_t;

	localparam logic [WordW-1:0] NumOffset = 64'h0002_0000_0000_0000;
	localparam logic [WordW-1:0] NegZero = 64'h8000_0000_0000_0000;

	// Decoded fields of a binary64 value, carried from stage 1 to stage 2.
	typedef struct packed {
		logic        is_num;
		logic        sign;
		logic [10:0] expo;
		logic [51:0] frac;
		logic        neg_zero;
		logic [CodeW-1:0] code;
	} dec_t;

	// Stage 2 result before sign application.
	typedef struct packed {
		logic        bad;
		logic        sign;
		logic [31:0] mag;
	} mag_t;
endpackage

>>> sv/boxed_double_to_int_check_core.sv
`timescale 1ns / 1ps
// Checks a NaN-boxed binary64 word against a small integer type and returns the
// exact integer or a reject flag. A three-stage pipeline (decode, shift to
// magnitude, range check) takes one beat per cycle while the output is not
// stalled; each result is registered through the decode, magnitude and range
// stages in turn, and a stall holds every stage in place.
module boxed_double_to_int_check_core import bdic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // boxed_word[63:0], opcode[66:64], zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata   // rejected[0], int_value[33:1], zero pad
);
	logic v_s1, v_s2, v_s3;
	logic adv;
	dec_t dec_c, dec_s1;
	mag_t mag_c, mag_s2;
	logic [CodeW-1:0] code_s2;
	logic rej_c, rej_s3;
	logic [ValW-1:0] val_c, val_s3;

	assign adv = m_tready || !m_tvalid;
	assign s_tready = adv;

	bdic_decode u_dec (.word(s_tdata[63:0]), .code(s_tdata[66:64]), .dec(dec_c));
	bdic_magnitude u_mag (.dec(dec_s1), .mag(mag_c));
	bdic_range u_rng (.mag(mag_s2), .code(code_s2), .rejected(rej_c), .int_value(val_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= dec_c;
			mag_s2 <= mag_c;
			code_s2 <= dec_s1.code;
			rej_s3 <= rej_c;
			val_s3 <= val_c;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata = {6'd0, val_s3, rej_s3};

`ifndef SYNTHESIS
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[33:1] == '0) else $error("reject with value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall lost");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1) else $error("beat dropped");
`endif
endmodule

>>> sv/bdic_decode.sv
`timescale 1ns / 1ps
module bdic_decode import bdic_pkg::*; (
	input  logic [WordW-1:0] word,
	input  logic [CodeW-1:0] code,
	output dec_t             dec
);
	logic [WordW-1:0] bits;
	always_comb begin
		bits = word - NumOffset;
		dec.is_num = (word >= NumOffset);
		dec.sign = bits[63];
		dec.expo = bits[62:52];
		dec.frac = bits[51:0];
		dec.neg_zero = (bits == NegZero);
		dec.code = code;
	end
endmodule

>>> sv/bdic_magnitude.sv
`timescale 1ns / 1ps
module bdic_magnitude import bdic_pkg::*; (
	input  dec_t dec,
	output mag_t mag
);
	logic [52:0] mant;
	logic [5:0]  sh;
	logic [84:0] wide;
	logic        zero;
	logic        big;
	logic        frac_bits;
	always_comb begin
		mant = {1'b1, dec.frac};
		zero = (dec.expo == 11'd0) && (dec.frac == 52'd0);
		// Values of 2^32 and above, infinities and NaN all count as too big.
		big = (dec.expo >= 11'd1055);
		sh = 6'd0;
		wide = '0;
		frac_bits = 1'b0;
		mag.mag = '0;
		if (zero) begin
			mag.mag = '0;
		end else if (dec.expo < 11'd1023) begin
			frac_bits = 1'b1;
		end else if (!big) begin
			sh = 6'(dec.expo - 11'd1023);
			wide = {32'd0, mant} << sh;
			mag.mag = wide[83:52];
			frac_bits = (wide[51:0] != 52'd0);
		end
		mag.bad = !dec.is_num || big || frac_bits || (dec.code > CODE_U32)
			|| (dec.neg_zero && (dec.code == CODE_I32 || dec.code == CODE_U32));
		mag.sign = dec.sign && !zero;
	end
endmodule

>>> sv/bdic_range.sv
`timescale 1ns / 1ps
module bdic_range import bdic_pkg::*; (
	input  mag_t             mag,
	input  logic [CodeW-1:0] code,
	output logic             rejected,
	output logic [ValW-1:0]  int_value
);
	logic [31:0] lim;
	logic        ok;
	always_comb begin
		case (code)
			CODE_I8:  lim = mag.sign ? 32'd128 : 32'd127;
			CODE_U8:  lim = mag.sign ? 32'd0 : 32'd255;
			CODE_I16: lim = mag.sign ? 32'd32768 : 32'd32767;
			CODE_U16: lim = mag.sign ? 32'd0 : 32'd65535;
			CODE_I32: lim = mag.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
			CODE_U32: lim = mag.sign ? 32'd0 : 32'hFFFF_FFFF;
			default:  lim = 32'd0;
		endcase
		ok = !mag.bad && (mag.mag <= lim);
		rejected = !ok;
		if (!ok) begin
			int_value = '0;
		end else if (mag.sign) begin
			int_value = -{1'b0, mag.mag};
		end else begin
			int_value = {1'b0, mag.mag};
		end
	end
endmodule
